// ===== design/tmps_pkg.sv =====
// ----------------------------------------------------------------------------
// tmps_pkg
// Shared widths, types and unit operation codes for the triangle path sum.
// ----------------------------------------------------------------------------
package tmps_pkg;

   localparam int ENTRY_W     = 16;
   localparam int SUM_W       = 20;
   localparam int BEST_W      = 21;
   localparam int ROW_COUNT_W = 5;

   localparam int DEFAULT_MAX_ROWS  = 16;
   localparam int DEFAULT_ROW_COUNT = 15;

   typedef logic [ENTRY_W-1:0]     entry_type;
   typedef logic [SUM_W-1:0]       sum_type;
   typedef logic [BEST_W-1:0]      best_type;
   typedef logic [ROW_COUNT_W-1:0] row_count_type;

   localparam best_type BEST_MAX = {BEST_W{1'b1}};
   localparam sum_type  SUM_MAX  = {SUM_W{1'b1}};

   typedef logic alu_op_type;
   localparam alu_op_type ALU_OP_MAX = 1'b0;
   localparam alu_op_type ALU_OP_ADD = 1'b1;

   typedef struct packed {
      alu_op_type op;
      best_type   a;
      best_type   b;
   } alu_req_type;

endpackage

// ===== design/tmps_if.sv =====
// ----------------------------------------------------------------------------
// tmps_if
// Valid/ready channels for triangle entries and path sum results.
// ----------------------------------------------------------------------------
interface tmps_req_if;
   import tmps_pkg::*;

   logic      valid;
   logic      ready;
   entry_type entry_value;

   modport source (output valid, output entry_value, input ready);
   modport sink   (input valid, input entry_value, output ready);
endinterface

interface tmps_rsp_if;
   import tmps_pkg::*;

   logic    valid;
   logic    ready;
   sum_type max_sum;

   modport source (output valid, output max_sum, input ready);
   modport sink   (input valid, input max_sum, output ready);
endinterface

// ===== design/tmps_alu.sv =====
// ----------------------------------------------------------------------------
// tmps_alu
// Shared unit: maximum of two best sums, or their saturating sum.
// ----------------------------------------------------------------------------
module tmps_alu (
   input  tmps_pkg::alu_req_type req,
   output tmps_pkg::best_type    result
);
   import tmps_pkg::*;

   logic [BEST_W:0] sum_w;

   assign sum_w = {1'b0, req.a} + {1'b0, req.b};

   always_comb begin
      unique case (req.op)
         ALU_OP_MAX: result = (req.a > req.b) ? req.a : req.b;
         ALU_OP_ADD: result = sum_w[BEST_W] ? BEST_MAX : sum_w[BEST_W-1:0];
         default:    result = req.a;
      endcase
   end

endmodule

// ===== design/triangle_max_path_sum.sv =====
// ----------------------------------------------------------------------------
// triangle_max_path_sum
// Top-down maximum path sum over a number triangle fed in row-major order.
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// req      in   valid/ready    entry_value[15:0], one triangle entry per word
// rsp      out  valid/ready    max_sum[19:0], one word after the bottom row
// csr      in   write enable   csr_write_data[4:0], row count
//
// each entry steps through accept with row buffer read, then three passes
// through the shared max/add unit (pick parent, add entry, update maximum)
// reset is synchronous; the row buffer is not cleared, unwritten entries are never used
// a csr write sends the position back to the apex
// the last entry's update cycle holds while the previous result word still waits on rsp
// ----------------------------------------------------------------------------
module triangle_max_path_sum #(
   parameter int MAX_ROWS = tmps_pkg::DEFAULT_MAX_ROWS
) (
   input  logic                    clock,
   input  logic                    reset,
   tmps_req_if.sink                req,
   tmps_rsp_if.source              rsp,
   input  logic                    csr_write_enable,
   input  tmps_pkg::row_count_type csr_write_data
);
   import tmps_pkg::*;

   localparam int IW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CW = 10;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PICK  = 2'd1;
   localparam logic [1:0] S_ADD   = 2'd2;
   localparam logic [1:0] S_WRITE = 2'd3;

   localparam logic [CW-1:0] MAX_ROWS_C = CW'(MAX_ROWS);

   logic [1:0]    state_ff, state_in;
   row_count_type row_count_ff;
   logic [IW-1:0] row_index_ff, row_index_in;
   logic [IW-1:0] column_index_ff, column_index_in;
   best_type      left_prev_ff, left_prev_in;
   best_type      running_max_ff, running_max_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sum_type       rsp_sum_ff, rsp_sum_in;

   entry_type     v_ff;
   logic [IW-1:0] r_ff;
   logic [IW-1:0] c_ff;
   best_type      above_ff;
   best_type      operand_ff, operand_in;
   best_type      best_ff, best_in;

   best_type      row_best [MAX_ROWS];

   logic [CW-1:0] rows_w;
   logic [CW-1:0] last_w;
   logic [IW-1:0] last;
   logic [IW-1:0] r_clamp;
   logic [IW-1:0] c_clamp;
   logic          accept;
   logic          emit;
   logic          go;
   logic          mem_we;
   alu_req_type   alu_req;
   best_type      alu_y;

   tmps_alu u_alu (
      .req    (alu_req),
      .result (alu_y)
   );

   // rows in use: zero counts as one, capped at the buffer depth
   always_comb begin
      rows_w = {{(CW-ROW_COUNT_W){1'b0}}, row_count_ff};
      if (rows_w == '0) begin
         rows_w = CW'(1);
      end
      if (rows_w > MAX_ROWS_C) begin
         rows_w = MAX_ROWS_C;
      end
   end

   assign last_w  = rows_w - CW'(1);
   assign last    = last_w[IW-1:0];
   assign r_clamp = (row_index_ff > last) ? last : row_index_ff;
   assign c_clamp = (column_index_ff > r_clamp) ? r_clamp : column_index_ff;

   assign req.ready   = (state_ff == S_IDLE);
   assign accept      = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.max_sum = rsp_sum_ff;

   assign emit   = (state_ff == S_WRITE) && (c_ff == r_ff) && (r_ff == last);
   assign go     = !(emit && rsp_valid_ff && !rsp.ready);
   assign mem_we = (state_ff == S_WRITE) && go;

   always_comb begin
      unique case (state_ff)
         S_PICK:  alu_req = '{op: ALU_OP_MAX, a: above_ff, b: left_prev_ff};
         S_ADD:   alu_req = '{op: ALU_OP_ADD, a: {{(BEST_W-ENTRY_W){1'b0}}, v_ff},
                              b: operand_ff};
         S_WRITE: alu_req = '{op: ALU_OP_MAX, a: best_ff, b: running_max_ff};
         default: alu_req = '{op: ALU_OP_MAX, a: '0, b: '0};
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      row_index_in    = row_index_ff;
      column_index_in = column_index_ff;
      left_prev_in    = left_prev_ff;
      running_max_in  = running_max_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp.ready;
      rsp_sum_in      = rsp_sum_ff;
      operand_in      = operand_ff;
      best_in         = best_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            priority if (c_ff == '0) begin
               operand_in = above_ff;
            end else if (c_ff == r_ff) begin
               operand_in = left_prev_ff;
            end else begin
               operand_in = alu_y;
            end
            state_in = S_ADD;
         end
         S_ADD: begin
            best_in  = (r_ff == '0) ? {{(BEST_W-ENTRY_W){1'b0}}, v_ff} : alu_y;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            if (go) begin
               left_prev_in = above_ff;
               if (r_ff == last) begin
                  running_max_in = (c_ff == '0) ? best_ff : alu_y;
               end
               if (c_ff == r_ff) begin
                  column_index_in = '0;
                  if (r_ff == last) begin
                     row_index_in = '0;
                     rsp_valid_in = 1'b1;
                     rsp_sum_in   = (running_max_in > {1'b0, SUM_MAX}) ? SUM_MAX
                                                                   : running_max_in[SUM_W-1:0];
                  end else begin
                     row_index_in = r_ff + IW'(1);
                  end
               end else begin
                  row_index_in    = r_ff;
                  column_index_in = c_ff + IW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_write_enable) begin
         row_index_in    = '0;
         column_index_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         row_count_ff    <= ROW_COUNT_W'(DEFAULT_ROW_COUNT);
         row_index_ff    <= '0;
         column_index_ff <= '0;
         left_prev_ff    <= '0;
         running_max_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         row_index_ff    <= row_index_in;
         column_index_ff <= column_index_in;
         left_prev_ff    <= left_prev_in;
         running_max_ff  <= running_max_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (csr_write_enable) begin
            row_count_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_sum_ff <= rsp_sum_in;
      operand_ff <= operand_in;
      best_ff    <= best_in;
      if (accept) begin
         v_ff <= req.entry_value;
         r_ff <= r_clamp;
         c_ff <= c_clamp;
      end
   end

   // row buffer: read at accept, written back in the update cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_best[c_ff] <= best_ff;
      end
      if (accept) begin
         above_ff <= row_best[c_clamp];
      end
   end

`ifndef SYNTH
   a_col_within_row: assert property (@(posedge clock) disable iff (reset)
      column_index_ff <= row_index_ff)
      else $error("column index beyond row index");

   a_latched_col_within_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (c_ff <= r_ff && r_ff <= last))
      else $error("latched position outside triangle");

   a_emit_gives_word: assert property (@(posedge clock) disable iff (reset)
      (emit && go) |=> rsp_valid_ff)
      else $error("bottom row end did not raise a result word");

   a_best_covers_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> (best_ff >= {{(BEST_W-ENTRY_W){1'b0}}, v_ff}))
      else $error("best sum below its own entry");

   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |=> (row_index_ff == '0 && column_index_ff == '0))
      else $error("row count write did not restart at apex");
`endif

endmodule
